[design/sim_pattern_packer_assert.svh]
// ----------------------------------------------------------------------------
// sim_pattern_packer assertion macros
// shared property wrappers for the pattern packer checks
// ----------------------------------------------------------------------------
`ifndef SIM_PATTERN_PACKER_ASSERT_SVH
`define SIM_PATTERN_PACKER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define SPP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked outside reset
`define SPP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/spp_pkg.sv]
// ----------------------------------------------------------------------------
// spp_pkg
// types and constants shared by the pattern packer modules
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package spp_pkg;

    localparam int WORD_BITS   = 32;
    localparam int BIT_W       = 5;
    localparam int VAR_W       = 10;
    localparam int WSEL_W      = 2;
    localparam int LIT_W       = VAR_W + 1;
    localparam int SLOT_W      = 7;
    localparam int BANK_W      = 16;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 96;
    localparam int OB_NEW_BANK = SLOT_W;

    localparam logic [BANK_W-1:0] BANK_MAX = '1;

    typedef enum logic [1:0] {
        ALU_OR   = 2'd0,
        ALU_SET  = 2'd1,
        ALU_FIND = 2'd2
    } t_alu_op;

    typedef struct packed {
        t_alu_op              op;
        logic [WORD_BITS-1:0] a;
        logic [WORD_BITS-1:0] b;
        logic [BIT_W-1:0]     bitpos;
        logic                 set_b;
    } t_alu_req;

    typedef struct packed {
        logic [WORD_BITS-1:0] y_a;
        logic [WORD_BITS-1:0] y_b;
        logic                 zero_found;
        logic [BIT_W-1:0]     zero_pos;
    } t_alu_rsp;

endpackage

[design/sim_pattern_packer.sv]
// ----------------------------------------------------------------------------
// sim_pattern_packer
// packs streamed literal patterns into a slot matrix of presence/value rows
//
// input stream carries one literal (tuser = 0) or one row-word read (tuser = 1);
// tlast closes a pattern. output stream carries one item per read and one per
// closed pattern. s_axis_tready is high only while the sequencer is idle.
// a literal reads one row word per cycle from the store ram into the shared
// word unit, which merges it into the occupied mask. a read registers its row
// words in the read state and loads the output register in the emit state.
// closing a pattern adds a mask scan of up to NUM_WORDS words (one word a
// cycle), a read-modify-write of the store for each buffered literal, and a
// load of the output register. when every slot is taken, the store is swept
// clean at one word a cycle, all NUM_VARS * NUM_WORDS entries, before the
// write-back. the same sweep runs after reset, and no item is accepted until
// it ends.
// the output register holds a finished item while m_axis_tready is low; new
// items are still accepted, and the sequencer only waits at its final step.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "sim_pattern_packer_assert.svh"

module sim_pattern_packer
    import spp_pkg::*;
#(
    parameter int NUM_VARS  = 1024,
    parameter int NUM_WORDS = 4,
    parameter int MAX_LITS  = 256
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // [9:0] var_index, [10] negated, [12:11] word_index, [15:13] zero
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] mode
    input  logic                   s_axis_tuser,
    input  logic                   s_axis_tlast,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // [6:0] slot, [7] new_bank, [23:8] bank_count, [24] overflow,
    // [56:25] value_word, [88:57] present_word, [95:89] zero
    output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int MEM_DEPTH = NUM_VARS * NUM_WORDS;
    localparam int MEM_AW    = $clog2(MEM_DEPTH);
    localparam int MEM_W     = 2 * WORD_BITS;
    localparam int WW        = (NUM_WORDS > 1) ? $clog2(NUM_WORDS) : 1;
    localparam int CNT_W     = $clog2(MAX_LITS + 1);
    localparam int LA_W      = (MAX_LITS > 1) ? $clog2(MAX_LITS) : 1;

    typedef enum logic [9:0] {
        S_CLEAR    = 10'b00_0000_0001,
        S_IDLE     = 10'b00_0000_0010,
        S_ABSORB   = 10'b00_0000_0100,
        S_READ     = 10'b00_0000_1000,
        S_SCAN_ISS = 10'b00_0001_0000,
        S_SCAN     = 10'b00_0010_0000,
        S_WB_LIT   = 10'b00_0100_0000,
        S_WB_MRD   = 10'b00_1000_0000,
        S_WB_MWR   = 10'b01_0000_0000,
        S_EMIT     = 10'b10_0000_0000
    } t_state;

    // control registers
    t_state                  r_state,    n_state;
    logic [MEM_AW-1:0]       r_clr_addr, n_clr_addr;
    logic [CNT_W-1:0]        r_count,    n_count;
    logic [CNT_W-1:0]        r_wb_idx,   n_wb_idx;
    logic [WW-1:0]           r_wcnt,     n_wcnt;
    logic [NUM_WORDS-1:0]    r_mvalid,   n_mvalid;
    logic                    r_dropped,  n_dropped;
    logic [BANK_W-1:0]       r_bank,     n_bank;
    logic                    r_nb,       n_nb;
    logic                    r_last,     n_last;
    logic                    r_is_read,  n_is_read;
    logic                    r_rd_ok,    n_rd_ok;
    logic                    r_m_tvalid, n_m_tvalid;

    // payload registers
    logic [MEM_AW-1:0]       r_base,      n_base;
    logic [WW-1:0]           r_slot_word, n_slot_word;
    logic [BIT_W-1:0]        r_slot_bit,  n_slot_bit;
    logic                    r_neg,       n_neg;
    logic [MEM_AW-1:0]       r_wb_addr,   n_wb_addr;
    logic [WORD_BITS-1:0]    r_res_vw,    n_res_vw;
    logic [WORD_BITS-1:0]    r_res_pw,    n_res_pw;
    logic [OUT_TDATA_W-1:0]  r_m_tdata,   n_m_tdata;

    // ram ports
    logic                    mem_we;
    logic [MEM_AW-1:0]       mem_waddr, mem_raddr;
    logic [MEM_W-1:0]        mem_wdata, mem_rdata;
    logic                    lit_we;
    logic [LA_W-1:0]         lit_waddr, lit_raddr;
    logic [LIT_W-1:0]        lit_wdata, lit_rdata;
    logic                    mask_we;
    logic [WW-1:0]           mask_waddr, mask_raddr;
    logic [WORD_BITS-1:0]    mask_wdata, mask_rdata;

    t_alu_req                alu_req;
    t_alu_rsp                alu_rsp;

    // input decode
    logic                    in_acc;
    logic                    in_mode;
    logic [VAR_W-1:0]        in_var;
    logic                    in_neg;
    logic [WSEL_W-1:0]       in_word;
    logic                    in_last;
    logic                    var_ok;
    logic                    word_ok;
    logic                    cnt_ok;
    logic [31:0]             rd_addr_w;
    logic [31:0]             lit_base_w;
    logic [31:0]             wb_addr_w;
    logic [31:0]             slot_wide;
    logic [WW-1:0]           wcnt_inc;
    logic [WORD_BITS-1:0]    mask_eff;
    logic                    emit_go;

    assign in_mode = s_axis_tuser;
    assign in_var  = s_axis_tdata[VAR_W-1:0];
    assign in_neg  = s_axis_tdata[VAR_W];
    assign in_word = s_axis_tdata[VAR_W+WSEL_W:VAR_W+1];
    assign in_last = s_axis_tlast;

    assign s_axis_tready = (r_state == S_IDLE);
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_m_tvalid;
    assign m_axis_tdata  = r_m_tdata;

    assign var_ok     = (32'(in_var) < NUM_VARS);
    assign word_ok    = (32'(in_word) < NUM_WORDS);
    assign cnt_ok     = (r_count < CNT_W'(MAX_LITS));
    assign rd_addr_w  = 32'(in_var) * 32'(NUM_WORDS) + 32'(in_word);
    assign lit_base_w = 32'(in_var) * 32'(NUM_WORDS);
    assign wb_addr_w  = 32'(lit_rdata[VAR_W-1:0]) * 32'(NUM_WORDS) + 32'(r_slot_word);
    assign slot_wide  = 32'({r_slot_word, r_slot_bit});
    assign wcnt_inc   = r_wcnt + 1'b1;
    assign mask_eff   = r_mvalid[r_wcnt] ? mask_rdata : '0;
    assign emit_go    = !r_m_tvalid || m_axis_tready;

    spp_ram #(
        .WIDTH (MEM_W),
        .DEPTH (MEM_DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    spp_ram #(
        .WIDTH (LIT_W),
        .DEPTH (MAX_LITS)
    ) u_lit_buf (
        .i_clk   (i_clk),
        .i_we    (lit_we),
        .i_waddr (lit_waddr),
        .i_wdata (lit_wdata),
        .i_raddr (lit_raddr),
        .o_rdata (lit_rdata)
    );

    spp_ram #(
        .WIDTH (WORD_BITS),
        .DEPTH (NUM_WORDS)
    ) u_mask (
        .i_clk   (i_clk),
        .i_we    (mask_we),
        .i_waddr (mask_waddr),
        .i_wdata (mask_wdata),
        .i_raddr (mask_raddr),
        .o_rdata (mask_rdata)
    );

    spp_alu u_alu (
        .i_req (alu_req),
        .o_rsp (alu_rsp)
    );

    // word unit operands by sequencer step
    always_comb begin
        alu_req.a      = mask_eff;
        alu_req.b      = mem_rdata[WORD_BITS-1:0];
        alu_req.bitpos = r_slot_bit;
        alu_req.set_b  = !r_neg;
        case (r_state)
            S_ABSORB: begin
                alu_req.op = ALU_OR;
            end
            S_WB_MWR: begin
                alu_req.op = ALU_SET;
                alu_req.a  = mem_rdata[WORD_BITS-1:0];
                alu_req.b  = mem_rdata[MEM_W-1:WORD_BITS];
            end
            default: begin
                alu_req.op = ALU_FIND;
            end
        endcase
    end

    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_count     = r_count;
        n_wb_idx    = r_wb_idx;
        n_wcnt      = r_wcnt;
        n_mvalid    = r_mvalid;
        n_dropped   = r_dropped;
        n_bank      = r_bank;
        n_nb        = r_nb;
        n_last      = r_last;
        n_is_read   = r_is_read;
        n_rd_ok     = r_rd_ok;
        n_m_tvalid  = r_m_tvalid && !m_axis_tready;
        n_base      = r_base;
        n_slot_word = r_slot_word;
        n_slot_bit  = r_slot_bit;
        n_neg       = r_neg;
        n_wb_addr   = r_wb_addr;
        n_res_vw    = r_res_vw;
        n_res_pw    = r_res_pw;
        n_m_tdata   = r_m_tdata;

        mem_we      = 1'b0;
        mem_waddr   = r_wb_addr;
        mem_wdata   = {alu_rsp.y_b, alu_rsp.y_a};
        mem_raddr   = r_base;
        lit_we      = 1'b0;
        lit_waddr   = r_count[LA_W-1:0];
        lit_wdata   = {in_neg, in_var};
        lit_raddr   = r_wb_idx[LA_W-1:0];
        mask_we     = 1'b0;
        mask_waddr  = r_wcnt;
        mask_wdata  = alu_rsp.y_a;
        mask_raddr  = r_wcnt;

        case (r_state)
            S_CLEAR: begin
                mem_we    = 1'b1;
                mem_waddr = r_clr_addr;
                mem_wdata = '0;
                if (r_clr_addr == MEM_AW'(MEM_DEPTH - 1)) begin
                    n_clr_addr = '0;
                    // a new bank goes on to write the pattern into slot 0
                    n_state    = r_nb ? S_WB_LIT : S_IDLE;
                end else begin
                    n_clr_addr = r_clr_addr + 1'b1;
                end
            end
            S_IDLE: begin
                if (in_acc) begin
                    n_last = in_last;
                    if (in_mode) begin
                        n_is_read = 1'b1;
                        n_rd_ok   = var_ok && word_ok;
                        mem_raddr = rd_addr_w[MEM_AW-1:0];
                        n_state   = S_READ;
                    end else begin
                        n_is_read = 1'b0;
                        if (var_ok && cnt_ok) begin
                            lit_we     = 1'b1;
                            n_count    = r_count + 1'b1;
                            mem_raddr  = lit_base_w[MEM_AW-1:0];
                            n_base     = lit_base_w[MEM_AW-1:0];
                            mask_raddr = '0;
                            n_wcnt     = '0;
                            n_state    = S_ABSORB;
                        end else begin
                            if (var_ok) begin
                                n_dropped = 1'b1;
                            end
                            n_state = in_last ? S_SCAN_ISS : S_IDLE;
                        end
                    end
                end
            end
            S_READ: begin
                n_res_pw = r_rd_ok ? mem_rdata[WORD_BITS-1:0] : '0;
                n_res_vw = r_rd_ok ? mem_rdata[MEM_W-1:WORD_BITS] : '0;
                n_state  = S_EMIT;
            end
            S_ABSORB: begin
                // merge word r_wcnt, fetch the next one in the same cycle
                mask_we          = 1'b1;
                n_mvalid[r_wcnt] = 1'b1;
                if (r_wcnt == WW'(NUM_WORDS - 1)) begin
                    n_wcnt  = '0;
                    n_state = r_last ? S_SCAN_ISS : S_IDLE;
                end else begin
                    n_wcnt     = wcnt_inc;
                    mem_raddr  = r_base + MEM_AW'(wcnt_inc);
                    mask_raddr = wcnt_inc;
                end
            end
            S_SCAN_ISS: begin
                mask_raddr = '0;
                n_wcnt     = '0;
                n_state    = S_SCAN;
            end
            S_SCAN: begin
                n_wb_idx = '0;
                if (alu_rsp.zero_found) begin
                    n_slot_word = r_wcnt;
                    n_slot_bit  = alu_rsp.zero_pos;
                    n_wcnt      = '0;
                    n_state     = S_WB_LIT;
                end else if (r_wcnt == WW'(NUM_WORDS - 1)) begin
                    // every slot taken: start a new bank in slot 0
                    n_slot_word = '0;
                    n_slot_bit  = '0;
                    n_nb        = 1'b1;
                    n_bank      = (r_bank == BANK_MAX) ? r_bank : r_bank + 1'b1;
                    n_wcnt      = '0;
                    n_clr_addr  = '0;
                    n_state     = S_CLEAR;
                end else begin
                    n_wcnt     = wcnt_inc;
                    mask_raddr = wcnt_inc;
                end
            end
            S_WB_LIT: begin
                if (r_wb_idx == r_count) begin
                    n_state = S_EMIT;
                end else begin
                    n_state = S_WB_MRD;
                end
            end
            S_WB_MRD: begin
                n_neg     = lit_rdata[VAR_W];
                n_wb_addr = wb_addr_w[MEM_AW-1:0];
                mem_raddr = wb_addr_w[MEM_AW-1:0];
                n_state   = S_WB_MWR;
            end
            S_WB_MWR: begin
                mem_we   = 1'b1;
                n_wb_idx = r_wb_idx + 1'b1;
                n_state  = S_WB_LIT;
            end
            S_EMIT: begin
                if (emit_go) begin
                    n_m_tvalid = 1'b1;
                    if (r_is_read) begin
                        n_m_tdata = OUT_TDATA_W'({r_res_pw, r_res_vw, r_dropped, r_bank,
                                                  1'b0, SLOT_W'(0)});
                    end else begin
                        n_m_tdata = OUT_TDATA_W'({WORD_BITS'(0), WORD_BITS'(0), r_dropped,
                                                  r_bank, r_nb, slot_wide[SLOT_W-1:0]});
                        n_count   = '0;
                        n_wb_idx  = '0;
                        n_mvalid  = '0;
                        n_dropped = 1'b0;
                        n_nb      = 1'b0;
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_clr_addr <= '0;
            r_count    <= '0;
            r_wb_idx   <= '0;
            r_wcnt     <= '0;
            r_mvalid   <= '0;
            r_dropped  <= 1'b0;
            r_bank     <= '0;
            r_nb       <= 1'b0;
            r_last     <= 1'b0;
            r_is_read  <= 1'b0;
            r_rd_ok    <= 1'b0;
            r_m_tvalid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_clr_addr <= n_clr_addr;
            r_count    <= n_count;
            r_wb_idx   <= n_wb_idx;
            r_wcnt     <= n_wcnt;
            r_mvalid   <= n_mvalid;
            r_dropped  <= n_dropped;
            r_bank     <= n_bank;
            r_nb       <= n_nb;
            r_last     <= n_last;
            r_is_read  <= n_is_read;
            r_rd_ok    <= n_rd_ok;
            r_m_tvalid <= n_m_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_base      <= n_base;
        r_slot_word <= n_slot_word;
        r_slot_bit  <= n_slot_bit;
        r_neg       <= n_neg;
        r_wb_addr   <= n_wb_addr;
        r_res_vw    <= n_res_vw;
        r_res_pw    <= n_res_pw;
        r_m_tdata   <= n_m_tdata;
    end

    `SPP_ASSERT_IMP(a_count_bound, 1'b1, r_count <= CNT_W'(MAX_LITS),
        "literal count beyond buffer depth")
    `SPP_ASSERT_IMP(a_wb_idx_bound, 1'b1, r_wb_idx <= r_count,
        "write-back index passed the literal count")
    `SPP_ASSERT_NXT(a_drop_flag, in_acc && !in_mode && var_ok && !cnt_ok, r_dropped,
        "literal dropped on a full buffer without the overflow flag")
    `SPP_ASSERT_NXT(a_emit_clears, r_state == S_EMIT && emit_go && !r_is_read,
        r_count == '0 && r_mvalid == '0 && !r_dropped,
        "pattern state not cleared after its item")
    `SPP_ASSERT_IMP(a_bank_slot0, m_axis_tvalid && m_axis_tdata[OB_NEW_BANK],
        m_axis_tdata[SLOT_W-1:0] == '0,
        "new bank item reports a slot other than zero")

endmodule

[design/spp_ram.sv]
// ----------------------------------------------------------------------------
// spp_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spp_ram #(
    parameter int  WIDTH = 32,
    parameter int  DEPTH = 16,
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/spp_alu.sv]
// ----------------------------------------------------------------------------
// spp_alu
// shared 32-bit word unit: or-merge, bit set, first-zero search
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module spp_alu
    import spp_pkg::*;
(
    input  t_alu_req i_req,
    output t_alu_rsp o_rsp
);

    logic [WORD_BITS-1:0] onehot;
    logic [BIT_W-1:0]     zpos;

    always_comb begin
        onehot = '0;
        onehot[i_req.bitpos] = 1'b1;
        // lowest zero wins, so scan from the top down
        zpos = '0;
        for (int i = WORD_BITS - 1; i >= 0; i--) begin
            if (!i_req.a[i]) begin
                zpos = BIT_W'(i);
            end
        end
        o_rsp.zero_found = ~&i_req.a;
        o_rsp.zero_pos   = zpos;
        case (i_req.op)
            ALU_OR: begin
                o_rsp.y_a = i_req.a | i_req.b;
                o_rsp.y_b = i_req.b;
            end
            ALU_SET: begin
                o_rsp.y_a = i_req.a | onehot;
                o_rsp.y_b = i_req.set_b ? (i_req.b | onehot) : i_req.b;
            end
            ALU_FIND: begin
                o_rsp.y_a = i_req.a;
                o_rsp.y_b = i_req.b;
            end
            default: begin
                o_rsp.y_a = i_req.a;
                o_rsp.y_b = i_req.b;
            end
        endcase
    end

endmodule

[sim/sim_pattern_packer_tb.sv]
// ----------------------------------------------------------------------------
// sim_pattern_packer_tb
// self-checking bench for the pattern packer: a directed table, then random
// literal patterns and row reads drawn from a hot variable pool so that slots
// fill up and new banks start. every output item is compared field by field
// against its table entry when typed, else a slot-matrix predictor kept in the bench
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sim_pattern_packer_tb;
    import spp_pkg::*;

    localparam int NUM_VARS    = 1024;
    localparam int NUM_WORDS   = 4;
    localparam int MAX_LITS    = 256;
    localparam int NUM_SLOTS   = WORD_BITS * NUM_WORDS;
    localparam int STORE_DEPTH = NUM_VARS * NUM_WORDS;
    localparam int RAND_ITEMS  = 1550;
    localparam int MAX_REPORTS = 10;

    typedef enum bit {
        MODE_LIT  = 1'b0,
        MODE_READ = 1'b1
    } t_mode;

    // field order matches m_axis_tdata from the top bit down
    typedef struct packed {
        logic [WORD_BITS-1:0] present_word;
        logic [WORD_BITS-1:0] value_word;
        logic                 overflow;
        logic [BANK_W-1:0]    bank_count;
        logic                 new_bank;
        logic [SLOT_W-1:0]    slot;
    } t_packer_out;

    localparam int OUT_USED_W = $bits(t_packer_out);

    typedef struct packed {
        t_mode             mode;
        logic [VAR_W-1:0]  var_idx;
        logic              neg;
        logic              last;
        logic [WSEL_W-1:0] wsel;
        logic              typed;
        t_packer_out       want;
    } t_stim_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    // [9:0] var_index, [10] negated, [12:11] word_index, [15:13] zero
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    // [0] mode
    logic                   s_axis_tuser;
    logic                   s_axis_tlast;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    // [6:0] slot, [7] new_bank, [23:8] bank_count, [24] overflow,
    // [56:25] value_word, [88:57] present_word, [95:89] zero
    logic [OUT_TDATA_W-1:0] m_axis_tdata;

    sim_pattern_packer #(
        .NUM_VARS  (NUM_VARS),
        .NUM_WORDS (NUM_WORDS),
        .MAX_LITS  (MAX_LITS)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // predicted slot matrix and pattern assembly state
    bit [WORD_BITS-1:0] pres_rows [STORE_DEPTH];
    bit [WORD_BITS-1:0] val_rows [STORE_DEPTH];
    bit [VAR_W-1:0]     lit_var [MAX_LITS];
    bit                 lit_neg [MAX_LITS];
    int                 lit_count;
    bit [NUM_SLOTS-1:0] occ_mask;
    bit [BANK_W-1:0]    banks_started;
    bit                 lits_dropped;

    t_packer_out pending_packer_outs [$];
    t_stim_row   directed_rows [0:18];

    int items_sent;
    int outputs_seen;
    int mismatch_count;
    int rx_hold;
    bit long_hold_done;
    bit quiet;

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    initial begin
        #6_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    task automatic slot_matrix_step(input t_mode mode, input logic [VAR_W-1:0] vi,
                                    input logic neg, input logic last,
                                    input logic [WSEL_W-1:0] wsel,
                                    output bit emits, output t_packer_out res);
        int  row;
        int  s;
        bit  found;
        res   = '0;
        emits = 1'b0;
        if (mode == MODE_READ) begin
            row = vi * NUM_WORDS + wsel;
            res.value_word   = val_rows[row];
            res.present_word = pres_rows[row];
            res.bank_count   = banks_started;
            res.overflow     = lits_dropped;
            emits = 1'b1;
            return;
        end
        if (lit_count < MAX_LITS) begin
            lit_var[lit_count] = vi;
            lit_neg[lit_count] = neg;
            lit_count++;
            for (int w = 0; w < NUM_WORDS; w++)
                occ_mask[w*WORD_BITS +: WORD_BITS] |= pres_rows[vi * NUM_WORDS + w];
        end else begin
            lits_dropped = 1'b1;
        end
        if (!last)
            return;
        found = 1'b0;
        s = 0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (!found && !occ_mask[i]) begin
                s = i;
                found = 1'b1;
            end
        end
        // every slot taken: the matrix starts over as a fresh bank
        if (!found) begin
            foreach (pres_rows[i]) begin
                pres_rows[i] = '0;
                val_rows[i]  = '0;
            end
            if (banks_started != BANK_MAX)
                banks_started++;
            s = 0;
            res.new_bank = 1'b1;
        end
        for (int i = 0; i < lit_count; i++) begin
            row = lit_var[i] * NUM_WORDS + s / WORD_BITS;
            pres_rows[row][s % WORD_BITS] = 1'b1;
            if (!lit_neg[i])
                val_rows[row][s % WORD_BITS] = 1'b1;
        end
        res.slot       = SLOT_W'(s);
        res.bank_count = banks_started;
        res.overflow   = lits_dropped;
        emits = 1'b1;
        lit_count    = 0;
        occ_mask     = '0;
        lits_dropped = 1'b0;
    endtask

    function automatic int idle_len();
        int roll;
        roll = $urandom_range(0, 99);
        if (quiet || roll < 60)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 30);
    endfunction

    task automatic send_item(input t_mode mode, input logic [VAR_W-1:0] vi,
                             input logic neg, input logic last,
                             input logic [WSEL_W-1:0] wsel,
                             input logic typed, input t_packer_out want);
        int          gap;
        bit          emits;
        t_packer_out res;
        gap = idle_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {{(IN_TDATA_W - VAR_W - 1 - WSEL_W){1'b0}}, wsel, neg, vi};
        s_axis_tuser  <= mode;
        s_axis_tlast  <= last;
        do @(posedge i_clk); while (!s_axis_tready);
        slot_matrix_step(mode, vi, neg, last, wsel, emits, res);
        if (emits)
            pending_packer_outs.push_back(typed ? want : res);
        items_sent++;
    endtask

    function automatic logic [VAR_W-1:0] pick_var();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 5)
            return VAR_W'($urandom_range(0, 1));
        if (roll < 7)
            return VAR_W'($urandom_range(2, 7));
        return VAR_W'($urandom_range(0, NUM_VARS - 1));
    endfunction

    task automatic send_random_read();
        send_item(MODE_READ, pick_var(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                  WSEL_W'($urandom_range(0, NUM_WORDS - 1)), 1'b0, '0);
    endtask

    task automatic check_output(input logic [OUT_TDATA_W-1:0] raw);
        t_packer_out got;
        t_packer_out want;
        got = raw[OUT_USED_W-1:0];
        outputs_seen++;
        if (pending_packer_outs.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS)
                $display("%0t: unexpected output item %h", $realtime, raw);
        end else begin
            want = pending_packer_outs.pop_front();
            if (got.slot !== want.slot || got.new_bank !== want.new_bank ||
                got.bank_count !== want.bank_count || got.overflow !== want.overflow ||
                got.value_word !== want.value_word ||
                got.present_word !== want.present_word ||
                raw[OUT_TDATA_W-1:OUT_USED_W] !== '0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS)
                    $display({"%0t: item %0d exp slot=%0d nb=%0d bank=%0d ov=%0d ",
                              "val=%h pres=%h got slot=%0d nb=%0d bank=%0d ov=%0d ",
                              "val=%h pres=%h pad=%h"},
                             $realtime, outputs_seen,
                             want.slot, want.new_bank, want.bank_count, want.overflow,
                             want.value_word, want.present_word,
                             got.slot, got.new_bank, got.bank_count, got.overflow,
                             got.value_word, got.present_word,
                             raw[OUT_TDATA_W-1:OUT_USED_W]);
            end
        end
    endtask

    // output side: check, then pick the next ready level
    always @(posedge i_clk) begin : rx_side
        int roll;
        if (i_rst_n && m_axis_tvalid && m_axis_tready)
            check_output(m_axis_tdata);
        // one long hold-off so the output register and the input both back up
        if (outputs_seen >= 60 && !long_hold_done) begin
            long_hold_done = 1'b1;
            rx_hold = 400;
        end
        roll = $urandom_range(0, 99);
        if (rx_hold > 0) begin
            m_axis_tready <= 1'b0;
            rx_hold--;
        end else if (quiet || roll < 70) begin
            m_axis_tready <= 1'b1;
        end else begin
            m_axis_tready <= 1'b0;
            rx_hold = (roll < 95) ? $urandom_range(0, 3) : $urandom_range(10, 40);
        end
    end

    initial begin
        int pat_no;
        int len;
        int roll;
        directed_rows = '{
            '{MODE_READ, 10'd0,    1'b0, 1'b0, 2'd0, 1'b1, '0},
            '{MODE_READ, 10'd1023, 1'b1, 1'b1, 2'd3, 1'b1, '0},
            '{MODE_LIT,  10'd1023, 1'b0, 1'b1, 2'd0, 1'b1, '0},
            '{MODE_READ, 10'd1023, 1'b0, 1'b0, 2'd0, 1'b1,
              '{value_word: 32'd1, present_word: 32'd1, default: '0}},
            '{MODE_LIT,  10'd1023, 1'b1, 1'b1, 2'd0, 1'b1, '{slot: 7'd1, default: '0}},
            '{MODE_READ, 10'd1023, 1'b0, 1'b0, 2'd0, 1'b1,
              '{value_word: 32'd1, present_word: 32'd3, default: '0}},
            '{MODE_LIT,  10'd0,    1'b0, 1'b0, 2'd0, 1'b0, '0},
            '{MODE_LIT,  10'd1023, 1'b0, 1'b0, 2'd3, 1'b0, '0},
            '{MODE_LIT,  10'd512,  1'b1, 1'b1, 2'd0, 1'b0, '0},
            '{MODE_READ, 10'd512,  1'b0, 1'b0, 2'd0, 1'b0, '0},
            '{MODE_READ, 10'd1023, 1'b0, 1'b0, 2'd1, 1'b0, '0},
            '{MODE_READ, 10'd0,    1'b0, 1'b1, 2'd2, 1'b0, '0},
            '{MODE_LIT,  10'd341,  1'b0, 1'b0, 2'd2, 1'b0, '0},
            '{MODE_LIT,  10'd682,  1'b1, 1'b1, 2'd0, 1'b0, '0},
            '{MODE_READ, 10'd682,  1'b0, 1'b0, 2'd0, 1'b0, '0},
            '{MODE_READ, 10'd341,  1'b1, 1'b0, 2'd0, 1'b0, '0},
            '{MODE_LIT,  10'd1023, 1'b0, 1'b1, 2'd0, 1'b0, '0},
            '{MODE_READ, 10'd1023, 1'b0, 1'b1, 2'd0, 1'b0, '0},
            '{MODE_READ, 10'd5,    1'b1, 1'b1, 2'd3, 1'b0, '0}
        };
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= MODE_LIT;
        s_axis_tlast  <= 1'b0;
        m_axis_tready <= 1'b0;
        lit_count      = 0;
        occ_mask       = '0;
        banks_started  = '0;
        lits_dropped   = 1'b0;
        items_sent     = 0;
        outputs_seen   = 0;
        mismatch_count = 0;
        rx_hold        = 0;
        long_hold_done = 1'b0;
        quiet          = 1'b0;
        foreach (pres_rows[i]) begin
            pres_rows[i] = '0;
            val_rows[i]  = '0;
        end
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (directed_rows[i])
            send_item(directed_rows[i].mode, directed_rows[i].var_idx, directed_rows[i].neg,
                      directed_rows[i].last, directed_rows[i].wsel, directed_rows[i].typed,
                      directed_rows[i].want);

        pat_no = 0;
        while (items_sent < RAND_ITEMS) begin
            pat_no++;
            quiet = (pat_no >= 70 && pat_no < 100);
            if (pat_no == 50) begin
                // sender backs off until the block has drained completely
                s_axis_tvalid <= 1'b0;
                do @(posedge i_clk); while (pending_packer_outs.size() != 0);
            end
            roll = $urandom_range(0, 99);
            if (roll < 15) begin
                send_random_read();
                continue;
            end
            // up to two long patterns: one fills the lit buffer exactly, one overruns
            if (pat_no == 25)
                len = MAX_LITS;
            else if (pat_no == 120)
                len = MAX_LITS + $urandom_range(1, 4);
            else if (roll < 75)
                len = $urandom_range(1, 4);
            else
                len = $urandom_range(5, 12);
            for (int k = 0; k < len; k++) begin
                if ($urandom_range(0, 99) < 8)
                    send_random_read();
                send_item(MODE_LIT, pick_var(), 1'($urandom_range(0, 1)), k == len - 1,
                          WSEL_W'($urandom_range(0, NUM_WORDS - 1)), 1'b0, '0);
            end
        end
        quiet = 1'b0;
        s_axis_tvalid <= 1'b0;

        while (pending_packer_outs.size() != 0)
            @(posedge i_clk);
        repeat (50) @(posedge i_clk);
        if (mismatch_count == 0 && pending_packer_outs.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
